// ===== hdl/lcct_pkg.sv =====
package lcct_pkg;

  localparam int NumDynConns = 4;
  localparam int NumSlots    = NumDynConns + 1;
  localparam int SlotW       = $clog2(NumSlots);

  localparam logic [7:0] InvalidId = 8'hFF;
  localparam logic [4:0] OpenMax   = 5'd31;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_ACTIVATE = 3'd1,
    OP_CLOSE    = 3'd2,
    OP_GET      = 3'd3,
    OP_ADD      = 3'd4,
    OP_TAKE     = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INACTIVE  = 3'd2,
    ST_NO_RES    = 3'd3,
    ST_NO_CLOSE  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_MAX_CREDITS    = 1'b0,
    CFG_CLOSED_CREDITS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/logical_connection_credit_table_core.sv =====
// Logical connection credit table. Slot 0 is the static connection, slots 1..4 dynamic.
// Input channel (in_valid/in_ready): one operation word per handshake carrying opcode,
// conn_id, dest_id, dest_type, credit_value and max_payload.
// Output channel (out_valid/out_ready): one result word per operation with status,
// credits_out, payload_out and open_count.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 max_credits,
// 1 closed_credits; write only while no operation is in flight.
// Flow: the operation word is loaded, then one slot is scanned per cycle, from slot 0
// for get, add and take and from slot 1 otherwise, until a match, the last slot or an
// immediate result; the result is registered, then copied to the free output register.
// A new operation is taken only once the previous result is in the output register.
// A finished result sits in the output register; the next operation is taken while
// it waits, and its own result holds until the receiver takes the previous word.
// Reset clears every slot, sets both config registers to 255 and the open count to
// one; the table is usable as soon as reset is released.
module logical_connection_credit_table_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [7:0] conn_id,
  input  logic [7:0] dest_id,
  input  logic [1:0] dest_type,
  input  logic [7:0] credit_value,
  input  logic [7:0] max_payload,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] credits_out,
  output logic [7:0] payload_out,
  output logic [4:0] open_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import lcct_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  lcct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcct_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .conn_id      (conn_id),
    .dest_id      (dest_id),
    .dest_type    (dest_type),
    .credit_value (credit_value),
    .max_payload  (max_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .credits_out  (credits_out),
    .payload_out  (payload_out),
    .open_count   (open_count),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

// ===== hdl/lcct_ctrl.sv =====
module lcct_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcct_pkg::dp_status_t   stat,
  output lcct_pkg::ctl_cmd_t     cmd
);
  import lcct_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/lcct_datapath.sv =====
module lcct_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lcct_pkg::ctl_cmd_t   cmd,
  output lcct_pkg::dp_status_t stat,
  input  logic [2:0]           opcode,
  input  logic [7:0]           conn_id,
  input  logic [7:0]           dest_id,
  input  logic [1:0]           dest_type,
  input  logic [7:0]           credit_value,
  input  logic [7:0]           max_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [7:0]           credits_out,
  output logic [7:0]           payload_out,
  output logic [4:0]           open_count,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import lcct_pkg::*;

  logic [7:0] max_credits;
  logic [7:0] closed_credits;

  logic [7:0] slot_conn_id   [NumSlots];
  logic [7:0] slot_dest_id   [NumSlots];
  logic [1:0] slot_dest_type [NumSlots];
  logic [7:0] slot_credits   [NumSlots];
  logic [7:0] slot_payload   [NumSlots];
  logic       slot_active    [NumSlots];
  logic [4:0] open_cnt;

  logic [2:0] op;
  logic [7:0] id;
  logic [7:0] did;
  logic [1:0] dty;
  logic [7:0] cval;
  logic [7:0] pay;
  logic [SlotW-1:0] idx;

  logic [2:0] res_status;
  logic [7:0] res_cr;
  logic [7:0] res_pl;

  logic [7:0] c_id, c_did, c_cr, c_pl;
  logic [1:0] c_dty;
  logic       c_act;
  logic [8:0] sum;

  logic [7:0] w_id, w_did, w_cr, w_pl;
  logic [1:0] w_dty;
  logic       w_act;
  logic [4:0] open_next;

  logic       hit;
  logic       immediate;
  logic       last;
  logic       done;
  logic [2:0] rs;
  logic [7:0] rcr;
  logic [7:0] rpl;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_credits    <= 8'hFF;
      closed_credits <= 8'hFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_CREDITS:    max_credits    <= cfg_data;
        CFG_CLOSED_CREDITS: closed_credits <= cfg_data;
        default:            max_credits    <= max_credits;
      endcase
    end
  end

  assign c_id  = slot_conn_id[idx];
  assign c_did = slot_dest_id[idx];
  assign c_dty = slot_dest_type[idx];
  assign c_cr  = slot_credits[idx];
  assign c_pl  = slot_payload[idx];
  assign c_act = slot_active[idx];
  assign sum   = {1'b0, c_cr} + {1'b0, cval};
  assign last  = (idx == SlotW'(NumSlots - 1));

  always_comb begin
    hit       = 1'b0;
    immediate = 1'b0;
    rs        = ST_NOT_FOUND;
    rcr       = '0;
    rpl       = '0;
    w_id      = c_id;
    w_did     = c_did;
    w_dty     = c_dty;
    w_cr      = c_cr;
    w_pl      = c_pl;
    w_act     = c_act;
    open_next = open_cnt;
    unique case (op)
      OP_CREATE: begin
        rs = ST_NO_RES;
        if (!c_act) begin
          hit   = 1'b1;
          rs    = ST_OK;
          w_did = did;
          w_dty = dty;
        end
      end
      OP_ACTIVATE: begin
        if (c_did == did && c_dty == dty) begin
          hit   = 1'b1;
          rs    = ST_OK;
          w_id  = id;
          w_pl  = pay;
          w_cr  = cval;
          w_act = 1'b1;
          rcr   = cval;
          rpl   = pay;
          if (open_cnt < OpenMax) open_next = open_cnt + 5'd1;
        end
      end
      OP_CLOSE: begin
        if (open_cnt <= 5'd1) begin
          immediate = 1'b1;
          rs        = ST_NO_CLOSE;
        end else if (c_act && c_id == id) begin
          hit       = 1'b1;
          rs        = ST_OK;
          w_id      = InvalidId;
          w_pl      = '0;
          w_cr      = closed_credits;
          w_did     = '0;
          w_dty     = '0;
          w_act     = 1'b0;
          rcr       = closed_credits;
          open_next = open_cnt - 5'd1;
        end
      end
      OP_GET, OP_ADD, OP_TAKE: begin
        if (c_id == id) begin
          hit = 1'b1;
          if (c_act || c_id == 8'd0) begin
            rs = ST_OK;
            if (op == OP_ADD) begin
              w_cr = (sum > {1'b0, max_credits}) ? max_credits : sum[7:0];
            end else if (op == OP_TAKE) begin
              if (c_cr != 8'd0) begin
                w_cr = c_cr - 8'd1;
              end else begin
                rs = ST_NO_RES;
              end
            end
            rcr = w_cr;
            rpl = c_pl;
          end else begin
            rs = ST_INACTIVE;
          end
        end
      end
      default: begin
        immediate = 1'b1;
      end
    endcase
  end

  assign done           = immediate || hit || last;
  assign stat.scan_done = done;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= opcode;
      id   <= conn_id;
      did  <= dest_id;
      dty  <= dest_type;
      cval <= credit_value;
      pay  <= max_payload;
    end
    if (cmd.step && done) begin
      res_status <= rs;
      res_cr     <= rcr;
      res_pl     <= rpl;
    end
    if (cmd.emit) begin
      status      <= res_status;
      credits_out <= res_cr;
      payload_out <= res_pl;
      open_count  <= open_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= (opcode == OP_GET || opcode == OP_ADD || opcode == OP_TAKE) ?
             SlotW'(0) : SlotW'(1);
    end else if (cmd.step && !done) begin
      idx <= idx + SlotW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSlots; i++) begin
        slot_conn_id[i]   <= '0;
        slot_dest_id[i]   <= '0;
        slot_dest_type[i] <= '0;
        slot_credits[i]   <= '0;
        slot_payload[i]   <= '0;
        slot_active[i]    <= 1'b0;
      end
      open_cnt <= 5'd1;
    end else if (cmd.step && hit) begin
      slot_conn_id[idx]   <= w_id;
      slot_dest_id[idx]   <= w_did;
      slot_dest_type[idx] <= w_dty;
      slot_credits[idx]   <= w_cr;
      slot_payload[idx]   <= w_pl;
      slot_active[idx]    <= w_act;
      open_cnt            <= open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_open_nonzero: assert property (@(posedge clk) disable iff (rst) open_cnt != 5'd0)
    else $error("open connection count reached zero");
  a_static_slot: assert property (@(posedge clk) disable iff (rst)
    slot_conn_id[0] == 8'd0 && !slot_active[0])
    else $error("static slot identity changed");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken word");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> idx <= SlotW'(NumSlots - 1))
    else $error("scan index beyond table");
  a_close_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && hit && op == OP_CLOSE) |=> open_cnt == $past(open_cnt) - 5'd1)
    else $error("close did not decrement open count");
`endif

endmodule

// ===== bench/tb_logical_connection_credit_table_core.sv =====
`timescale 1ns / 100ps

module tb_logical_connection_credit_table_core;
  import lcct_pkg::*;

  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] cr;
    logic [7:0] pl;
    logic [4:0] opens;
  } conn_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] opcode = '0;
  logic [7:0] conn_id = '0;
  logic [7:0] dest_id = '0;
  logic [1:0] dest_type = '0;
  logic [7:0] credit_value = '0;
  logic [7:0] max_payload = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] credits_out;
  logic [7:0] payload_out;
  logic [4:0] open_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic [7:0] tbl_conn  [NumSlots];
  logic [7:0] tbl_dest  [NumSlots];
  logic [1:0] tbl_dtype [NumSlots];
  logic [7:0] tbl_cred  [NumSlots];
  logic [7:0] tbl_pay   [NumSlots];
  logic       tbl_live  [NumSlots];
  logic [4:0] tbl_open;
  logic [7:0] lim_max_cred;
  logic [7:0] lim_close_cred;

  conn_reply_t due_replies[$];
  int          mismatches = 0;
  int          tx_idle_pct = 38;
  int          rx_idle_pct = 62;
  logic        word_held = 1'b0;

  logical_connection_credit_table_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void table_reset();
    for (int i = 0; i < NumSlots; i++) begin
      tbl_conn[i]  = '0;
      tbl_dest[i]  = '0;
      tbl_dtype[i] = '0;
      tbl_cred[i]  = '0;
      tbl_pay[i]   = '0;
      tbl_live[i]  = 1'b0;
    end
    tbl_open       = 5'd1;
    lim_max_cred   = 8'hFF;
    lim_close_cred = 8'hFF;
  endfunction

  function automatic conn_reply_t table_apply(input logic [2:0] op, input logic [7:0] id,
                                              input logic [7:0] dest, input logic [1:0] dty,
                                              input logic [7:0] cval, input logic [7:0] pay);
    conn_reply_t r;
    int          hit;
    logic [8:0]  sum;
    r.st = ST_NOT_FOUND;
    r.cr = '0;
    r.pl = '0;
    hit  = -1;
    case (op)
      OP_CREATE: begin
        r.st = ST_NO_RES;
        for (int i = NumSlots - 1; i >= 1; i--) if (!tbl_live[i]) hit = i;
        if (hit > 0) begin
          tbl_dest[hit]  = dest;
          tbl_dtype[hit] = dty;
          r.st = ST_OK;
        end
      end
      OP_ACTIVATE: begin
        for (int i = NumSlots - 1; i >= 1; i--)
          if (tbl_dest[i] == dest && tbl_dtype[i] == dty) hit = i;
        if (hit > 0) begin
          tbl_conn[hit] = id;
          tbl_pay[hit]  = pay;
          tbl_cred[hit] = cval;
          tbl_live[hit] = 1'b1;
          if (tbl_open < OpenMax) tbl_open++;
          r.st = ST_OK;
          r.cr = cval;
          r.pl = pay;
        end
      end
      OP_CLOSE: begin
        if (tbl_open > 5'd1) begin
          for (int i = NumSlots - 1; i >= 1; i--)
            if (tbl_live[i] && tbl_conn[i] == id) hit = i;
          if (hit > 0) begin
            tbl_conn[hit]  = InvalidId;
            tbl_pay[hit]   = '0;
            tbl_cred[hit]  = lim_close_cred;
            tbl_dest[hit]  = '0;
            tbl_dtype[hit] = '0;
            tbl_live[hit]  = 1'b0;
            tbl_open--;
            r.st = ST_OK;
            r.cr = lim_close_cred;
          end
        end else begin
          r.st = ST_NO_CLOSE;
        end
      end
      OP_GET, OP_ADD, OP_TAKE: begin
        for (int i = NumSlots - 1; i >= 0; i--) if (tbl_conn[i] == id) hit = i;
        if (hit < 0) begin
          r.st = ST_NOT_FOUND;
        end else if (!tbl_live[hit] && tbl_conn[hit] != 8'd0) begin
          r.st = ST_INACTIVE;
        end else begin
          r.st = ST_OK;
          if (op == OP_ADD) begin
            sum = {1'b0, tbl_cred[hit]} + {1'b0, cval};
            if (sum > {1'b0, lim_max_cred}) sum = {1'b0, lim_max_cred};
            tbl_cred[hit] = sum[7:0];
          end else if (op == OP_TAKE) begin
            if (tbl_cred[hit] != 8'd0) tbl_cred[hit]--;
            else r.st = ST_NO_RES;
          end
          r.cr = tbl_cred[hit];
          r.pl = tbl_pay[hit];
        end
      end
      default: ;
    endcase
    r.opens = tbl_open;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    conn_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        flag_mismatch("result word with none due", int'(status), 0);
      end else begin
        want = due_replies.pop_front();
        if (status !== want.st)
          flag_mismatch("status", int'(status), int'(want.st));
        if (credits_out !== want.cr)
          flag_mismatch("credits_out", int'(credits_out), int'(want.cr));
        if (payload_out !== want.pl)
          flag_mismatch("payload_out", int'(payload_out), int'(want.pl));
        if (open_count !== want.opens)
          flag_mismatch("open_count", int'(open_count), int'(want.opens));
      end
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [7:0] id, input logic [7:0] dest,
                         input logic [1:0] dty, input logic [7:0] cval, input logic [7:0] pay);
    if ($urandom_range(99) < tx_idle_pct) begin
      if (word_held) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    word_held = 1'b1;
    in_valid     <= 1'b1;
    opcode       <= op;
    conn_id      <= id;
    dest_id      <= dest;
    dest_type    <= dty;
    credit_value <= cval;
    max_payload  <= pay;
    do @(posedge clk); while (!(in_valid && in_ready));
    due_replies.push_back(table_apply(op, id, dest, dty, cval, pay));
  endtask

  task automatic drain_replies();
    if (word_held) in_valid <= 1'b0;
    word_held = 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_MAX_CREDITS:    lim_max_cred   = value;
      CFG_CLOSED_CREDITS: lim_close_cred = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [7:0] max_c, input logic [7:0] closed_c);
    drain_replies();
    put_reg(CFG_MAX_CREDITS, max_c);
    put_reg(CFG_CLOSED_CREDITS, closed_c);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_id();
    logic [7:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = tbl_conn[$urandom_range(NumSlots - 1)];
      5:             v = 8'd0;
      6:             v = InvalidId;
      default:       v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic send_random_op();
    logic [2:0] op;
    logic [7:0] id, dest, cval, pay;
    logic [1:0] dty;
    int         pick, s;
    pick = $urandom_range(99);
    pay  = 8'($urandom_range(255));
    if (pick < 10) begin
      op   = 3'($urandom_range(7));
      id   = 8'($urandom_range(255));
      dest = 8'($urandom_range(255));
      dty  = 2'($urandom_range(3));
      cval = 8'($urandom_range(255));
    end else begin
      if (pick < 25)      op = OP_CREATE;
      else if (pick < 45) op = OP_ACTIVATE;
      else if (pick < 57) op = OP_CLOSE;
      else if (pick < 70) op = OP_GET;
      else if (pick < 85) op = OP_ADD;
      else                op = OP_TAKE;
      if (op == OP_ACTIVATE && $urandom_range(1) == 0) id = 8'($urandom_range(15));
      else id = pick_id();
      if ($urandom_range(9) < 7) begin
        s    = $urandom_range(NumDynConns, 1);
        dest = tbl_dest[s];
        dty  = tbl_dtype[s];
      end else begin
        case ($urandom_range(3))
          0:       dest = 8'h00;
          1:       dest = 8'h3C;
          2:       dest = 8'hC3;
          default: dest = 8'hFF;
        endcase
        dty = 2'($urandom_range(3));
      end
      case ($urandom_range(4))
        0:       cval = 8'd0;
        1:       cval = 8'hFF;
        2, 3:    cval = 8'($urandom_range(4, 1));
        default: cval = 8'($urandom_range(255));
      endcase
    end
    send_op(op, id, dest, dty, cval, pay);
  endtask

  task automatic test_directed_ops();
    send_op(OP_GET,      8'h00, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_TAKE,     8'h00, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_ADD,      8'h00, 8'h00, 2'd0, 8'hFF, 8'h00);
    send_op(OP_ADD,      8'h00, 8'h00, 2'd0, 8'h01, 8'h00);
    send_op(OP_TAKE,     8'h00, 8'hFF, 2'd3, 8'hFF, 8'hFF);
    send_op(OP_GET,      8'h07, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_CLOSE,    8'h00, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_CREATE,   8'h00, 8'hFF, 2'd3, 8'h00, 8'h00);
    send_op(OP_ACTIVATE, 8'h55, 8'hFF, 2'd3, 8'h00, 8'hFF);
    send_op(OP_ACTIVATE, 8'hAA, 8'h00, 2'd0, 8'h03, 8'h80);
    send_op(OP_ACTIVATE, 8'h66, 8'h12, 2'd1, 8'h09, 8'h20);
    send_op(OP_TAKE,     8'h55, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_ADD,      8'h55, 8'h00, 2'd0, 8'd200, 8'h00);
    send_op(OP_ADD,      8'h55, 8'h00, 2'd0, 8'd100, 8'h00);
    send_op(OP_CREATE,   8'h00, 8'h01, 2'd1, 8'h00, 8'h00);
    send_op(OP_CREATE,   8'h00, 8'h02, 2'd2, 8'h00, 8'h00);
    send_op(OP_ACTIVATE, 8'h10, 8'h02, 2'd2, 8'h01, 8'h01);
    send_op(OP_CREATE,   8'h00, 8'h03, 2'd0, 8'h00, 8'h00);
    send_op(OP_ACTIVATE, 8'h20, 8'h03, 2'd0, 8'hFF, 8'h00);
    send_op(OP_CREATE,   8'h00, 8'h04, 2'd1, 8'h00, 8'h00);
    send_op(OP_ACTIVATE, 8'h11, 8'h02, 2'd2, 8'h05, 8'h40);
    send_op(OP_CLOSE,    8'h55, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_GET,      8'h55, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_GET,      InvalidId, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_CLOSE,    8'h77, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OpSpareLo,   8'hFF, 8'hFF, 2'd3, 8'hFF, 8'hFF);
    send_op(OpSpareHi,   8'h11, 8'h02, 2'd2, 8'h05, 8'h40);
    drain_replies();
  endtask

  task automatic test_credit_limits();
    set_limits(8'h00, 8'h00);
    send_op(OP_ADD,   8'h00, 8'h00, 2'd0, 8'h05, 8'h00);
    send_op(OP_TAKE,  8'h00, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_ADD,   8'h11, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_CLOSE, 8'h11, 8'h00, 2'd0, 8'h00, 8'h00);
    set_limits(8'h01, 8'h80);
    send_op(OP_ADD,   8'h00, 8'h00, 2'd0, 8'hFF, 8'h00);
    send_op(OP_CLOSE, 8'h20, 8'h00, 2'd0, 8'h00, 8'h00);
    send_op(OP_GET,   InvalidId, 8'h00, 2'd0, 8'h00, 8'h00);
    drain_replies();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [7:0] max_c, input logic [7:0] closed_c,
                                     input int count);
    set_limits(max_c, closed_c);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_op();
    drain_replies();
  endtask

  initial begin
    table_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_credit_limits();
    test_random_traffic(38, 62, 8'hFF, 8'hFF, 275);
    test_random_traffic(62, 38, 8'($urandom_range(200, 8)), 8'($urandom_range(255)), 275);
    test_random_traffic(0, 0, 8'h03, 8'h00, 275);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
